### design/pud_pkg.sv
// ----------------------------------------------------------------------------
// pud_pkg
// Shared types, character codes and the hex digit decoder used by the
// percent/URL decoder front end, request queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package pud_pkg;

  // character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // reset value of the output limit register
  localparam logic [15:0] MAX_OUT_RESET = 16'd2047;

  // results one request can cause, and queue sizing
  localparam int NRES   = 3;
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // escape tracking phases
  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  // one result item
  typedef struct packed {
    logic [7:0] value;
    logic       data;
    logic       last;
  } res_t;

  // one queue entry: the results a request causes, before the limit
  typedef struct packed {
    logic [1:0]           num;
    res_t [NRES-1:0]      res;
  } entry_t;

  // decoded hex digit
  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.nib = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.ok  = 1'b1;
      h.nib = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

### design/pud_in_if.sv
// ----------------------------------------------------------------------------
// pud_in_if
// Input channel of the decoder: one raw byte or an end-of-string marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface pud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_end;

  modport source (output valid, output in_byte, output in_end, input ready);
  modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

`default_nettype wire

### design/pud_out_if.sv
// ----------------------------------------------------------------------------
// pud_out_if
// Output channel of the decoder: one decoded byte or the end marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface pud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_data;
  logic       out_last;

  modport source (output valid, output out_byte, output out_data, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_data, input out_last,
                  output ready);
endinterface

`default_nettype wire

### design/pud_front.sv
// ----------------------------------------------------------------------------
// pud_front
// Accepts raw bytes, tracks the percent escape and turns each request into
// a queue entry of up to three results (before the output limit) for each request that yields any.
// ----------------------------------------------------------------------------
`default_nettype none

module pud_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             valid,
  output logic                  ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_end,
  input  wire logic             q_full,
  output logic                  push,
  output pud_pkg::entry_t       push_entry
);

  pud_pkg::phase_t phase, phase_next;
  logic [7:0]      held, held_next;
  pud_pkg::entry_t ent;
  pud_pkg::hex_t   lo, hi;
  logic            accept;

  assign ready  = !q_full;
  assign accept = valid && ready;

  // classify the request and collect its results
  always_comb begin
    logic [1:0] n;
    logic       brk;
    ent        = '0;
    n          = 2'd0;
    brk        = 1'b0;
    phase_next = phase;
    held_next  = held;
    lo         = pud_pkg::hex_decode(in_byte);
    hi         = pud_pkg::hex_decode(held);
    if (in_end) begin
      // flush pending escape, then the end marker
      if (phase == pud_pkg::PH_PCT || phase == pud_pkg::PH_DIGIT) begin
        ent.res[n] = '{value: pud_pkg::CH_PERCENT, data: 1'b1, last: 1'b0};
        n = n + 2'd1;
      end
      if (phase == pud_pkg::PH_DIGIT) begin
        ent.res[n] = '{value: held, data: 1'b1, last: 1'b0};
        n = n + 2'd1;
      end
      ent.res[n] = '{value: 8'h00, data: 1'b0, last: 1'b1};
      n = n + 2'd1;
      phase_next = pud_pkg::PH_PLAIN;
      held_next  = 8'h00;
    end else begin
      case (phase)
        pud_pkg::PH_PCT: begin
          if (lo.ok) begin
            held_next  = in_byte;
            phase_next = pud_pkg::PH_DIGIT;
          end else begin
            ent.res[n] = '{value: pud_pkg::CH_PERCENT, data: 1'b1, last: 1'b0};
            n = n + 2'd1;
            brk = 1'b1;
          end
        end
        pud_pkg::PH_DIGIT: begin
          if (lo.ok) begin
            ent.res[n] = '{value: {hi.nib, lo.nib}, data: 1'b1, last: 1'b0};
            n = n + 2'd1;
            phase_next = pud_pkg::PH_PLAIN;
          end else begin
            ent.res[n] = '{value: pud_pkg::CH_PERCENT, data: 1'b1, last: 1'b0};
            n = n + 2'd1;
            ent.res[n] = '{value: held, data: 1'b1, last: 1'b0};
            n = n + 2'd1;
            brk = 1'b1;
          end
          held_next = lo.ok ? 8'h00 : held;
          if (!lo.ok) held_next = 8'h00;
        end
        default: begin
          brk = 1'b1;
        end
      endcase
      // plain byte handling, also for the byte that broke an escape
      if (brk) begin
        phase_next = pud_pkg::PH_PLAIN;
        if (in_byte == pud_pkg::CH_PERCENT) begin
          phase_next = pud_pkg::PH_PCT;
        end else if (in_byte == pud_pkg::CH_PLUS) begin
          ent.res[n] = '{value: pud_pkg::CH_SPACE, data: 1'b1, last: 1'b0};
          n = n + 2'd1;
        end else begin
          ent.res[n] = '{value: in_byte, data: 1'b1, last: 1'b0};
          n = n + 2'd1;
        end
      end
    end
    ent.num = n;
  end

  assign push       = accept && (ent.num != 2'd0);
  assign push_entry = ent;

  // escape state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pud_pkg::PH_PLAIN;
      held  <= 8'h00;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

endmodule

`default_nettype wire

### design/pud_queue.sv
// ----------------------------------------------------------------------------
// pud_queue
// Short FIFO of decoded entries between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pud_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire pud_pkg::entry_t  push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output pud_pkg::entry_t       head
);

  pud_pkg::entry_t              slots [pud_pkg::QDEPTH];
  logic [pud_pkg::QAW-1:0]      wptr, rptr;
  logic [pud_pkg::QAW:0]        count;

  assign full       = (count == (pud_pkg::QAW+1)'(pud_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_entry;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= (pud_pkg::QAW+1)'(pud_pkg::QDEPTH))
    else $error("queue fill level out of range");
`endif

endmodule

`default_nettype wire

### design/pud_back.sv
// ----------------------------------------------------------------------------
// pud_back
// Walks the results of each queue entry, applies the per-string output
// limit and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pud_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [15:0]      max_out_bytes,
  input  wire logic             head_valid,
  input  wire pud_pkg::entry_t  head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pud_pkg::res_t         out_res
);

  logic [1:0]     sidx;
  logic [15:0]    count;
  pud_pkg::res_t  cur;
  logic           drop, out_free, take, last_slot;

  // current result and its fate
  assign cur       = head.res[sidx];
  assign drop      = cur.data && (count >= max_out_bytes);
  assign out_free  = !out_valid || out_ready;
  assign take      = head_valid && (drop || out_free);
  assign last_slot = (sidx == head.num - 2'd1);
  assign pop       = take && last_slot;

  // slot walk and emitted byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      sidx  <= 2'd0;
      count <= 16'd0;
    end else if (take) begin
      sidx <= last_slot ? 2'd0 : sidx + 2'd1;
      if (cur.last) begin
        count <= 16'd0;
      end else if (!drop && cur.data) begin
        count <= count + 16'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && !drop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !drop) out_res <= cur;
  end

`ifndef SYNTHESIS
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
      head_valid |-> (sidx < head.num))
    else $error("slot index beyond entry");
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
      (take && cur.last) |=> (count == 16'd0))
    else $error("byte count not cleared at end of string");
  a_end_not_dropped: assert property (@(posedge clk) disable iff (rst)
      (take && cur.last) |=> (out_valid && out_res.last))
    else $error("end marker lost");
`endif

endmodule

`default_nettype wire

### design/percent_url_decoder_unit.sv
// ----------------------------------------------------------------------------
// percent_url_decoder_unit
// Streaming URL percent/plus decoder with a per-string output limit.
// ----------------------------------------------------------------------------
// Path: the first result of a request passes through the queue, then the output register.
// Throughput: one request per cycle while each request yields at most one result and
// the output is not stalled; a request yielding k results (k up to 3) holds the back end
// while it walks its result slots one by one, including bytes dropped by the limit.
// Reset (rst, synchronous): escape state, byte count and queue cleared, limit 2047.
`default_nettype none

module percent_url_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  pud_in_if.sink           in_ch,
  pud_out_if.source        out_ch
);

  logic [15:0]      max_out_bytes;
  logic             q_full, push, pop, head_valid, out_valid;
  pud_pkg::entry_t  push_entry, head;
  pud_pkg::res_t    out_res;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_bytes <= pud_pkg::MAX_OUT_RESET;
    end else if (cfg_we) begin
      max_out_bytes <= cfg_wdata;
    end
  end

  // front end: escape tracking
  pud_front u_front (
    .clk        (clk),
    .rst        (rst),
    .valid      (in_ch.valid),
    .ready      (in_ch.ready),
    .in_byte    (in_ch.in_byte),
    .in_end     (in_ch.in_end),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // request queue
  pud_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back end: limit and output
  pud_back u_back (
    .clk           (clk),
    .rst           (rst),
    .max_out_bytes (max_out_bytes),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ch.ready),
    .out_res       (out_res)
  );

  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_res.value;
  assign out_ch.out_data = out_res.data;
  assign out_ch.out_last = out_res.last;

endmodule

`default_nettype wire
